FILE: hdl/byte_block_rotation_cipher_top_defines.svh
// Assertion macros shared by the byte block rotation cipher RTL.
`ifndef BYTE_BLOCK_ROTATION_CIPHER_TOP_DEFINES_SVH
`define BYTE_BLOCK_ROTATION_CIPHER_TOP_DEFINES_SVH

// The condition must never hold at a clock edge outside reset.
`define BBRC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BBRC_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBRC_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/bbrc_pkg.sv
// Package with shared types and constants of the byte block rotation cipher.
`timescale 1ns / 1ps
package bbrc_pkg;

	localparam int MAX_BLOCK_DEF    = 15;
	localparam int SCHEDULE_LEN_DEF = 8;
	localparam int LENGTH_BITS_DEF  = 16;

	localparam int NIB_W     = 4;
	localparam int NIB_COUNT = 8;
	localparam int KEY_BYTES = 4;
	localparam int HDR_BYTES = 4;
	localparam int TAIL_W    = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       message_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// Description of the output bytes caused by one input byte.
	typedef struct packed {
		logic              load;
		logic              key_en;
		logic [31:0]       key;
		logic              b_en;
		logic [7:0]        b;
		logic [TAIL_W-1:0] tail_cnt;
	} run_desc_t;

endpackage

FILE: hdl/bbrc_core.sv
// Cipher state and per-byte transform that builds the output run description.
`timescale 1ns / 1ps
module bbrc_core #(
	parameter int MAX_BLOCK    = bbrc_pkg::MAX_BLOCK_DEF,
	parameter int SCHEDULE_LEN = bbrc_pkg::SCHEDULE_LEN_DEF,
	parameter int LENGTH_BITS  = bbrc_pkg::LENGTH_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  bbrc_pkg::in_item_t         item,
	input  logic                       direction,
	input  logic [31:0]                key_word,
	input  logic [15:0]                payload_length,
	output bbrc_pkg::run_desc_t        desc,
	output logic [MAX_BLOCK-2:0][7:0]  held
);

	localparam int POS_W  = $clog2(MAX_BLOCK);
	localparam int LEN_W  = $clog2(MAX_BLOCK + 1);
	localparam int E_W    = LEN_W + 1;
	localparam int HIDX_W = (MAX_BLOCK > 2) ? $clog2(MAX_BLOCK - 1) : 1;
	localparam int SI_W   = $clog2(SCHEDULE_LEN);
	localparam int CMP_W  = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;
	localparam logic [SI_W-1:0] SI_LAST = SI_W'(SCHEDULE_LEN - 1);
	localparam logic [LENGTH_BITS-1:0] BD_MAX = '1;

	logic [bbrc_pkg::NIB_COUNT-1:0][bbrc_pkg::NIB_W-1:0] lengths_q, lengths_e, lengths_n;
	logic [SI_W-1:0]        si_q, si_e, si_n;
	logic [LENGTH_BITS-1:0] bd_q, bd_e, bd_n;
	logic [2:0]             hc_q, hc_e, hc_n;
	logic [POS_W-1:0]       pos_q, pos_e, pos_n;
	logic                   pt_q, pt_e, pt_n, pt_hit;
	logic [MAX_BLOCK-2:0][7:0] held_q;

	logic                      st, enc, key_load, hdr, pass_chk, blk_end;
	logic [bbrc_pkg::NIB_W-1:0] nib;
	logic [LEN_W-1:0]          len;
	logic                      b_en;
	logic [bbrc_pkg::TAIL_W-1:0] tail;
	logic                      held_we;
	logic [HIDX_W-1:0]         held_wa;

	always_comb begin
		st       = item.message_start;
		enc      = (direction == bbrc_pkg::DIR_ENCRYPT);
		key_load = st && enc;
		si_e     = st ? '0 : si_q;
		bd_e     = st ? '0 : bd_q;
		hc_e     = st ? '0 : hc_q;
		pos_e    = st ? '0 : pos_q;
		pt_e     = st ? 1'b0 : pt_q;
		for (int i = 0; i < bbrc_pkg::NIB_COUNT; i++) begin
			lengths_e[i] = key_load ? key_word[bbrc_pkg::NIB_W * (bbrc_pkg::NIB_COUNT - 1 - i) +:
				bbrc_pkg::NIB_W] : lengths_q[i];
		end
		hdr = !enc && (hc_e < 3'(bbrc_pkg::HDR_BYTES));

		nib = lengths_e[3'(si_e)];
		if (nib == '0) begin
			len = LEN_W'(1);
		end else if (nib > bbrc_pkg::NIB_W'(MAX_BLOCK)) begin
			len = LEN_W'(MAX_BLOCK);
		end else begin
			len = LEN_W'(nib);
		end
		pass_chk = CMP_W'(payload_length) <= (CMP_W'(bd_e) + CMP_W'(len));
		pt_hit   = pt_e || ((pos_e == '0) && pass_chk);
		blk_end  = (E_W'(pos_e) + E_W'(1)) >= E_W'(len);

		lengths_n = lengths_e;
		si_n      = si_e;
		bd_n      = bd_e;
		hc_n      = hc_e;
		pos_n     = pos_e;
		pt_n      = pt_e;
		b_en      = 1'b0;
		tail      = '0;
		held_we   = 1'b0;
		held_wa   = '0;

		if (hdr) begin
			lengths_n[{hc_e[1:0], 1'b0}] = item.in_byte[7:4];
			lengths_n[{hc_e[1:0], 1'b1}] = item.in_byte[3:0];
			hc_n = hc_e + 3'd1;
		end else begin
			bd_n = (bd_e == BD_MAX) ? bd_e : bd_e + 1'b1;
			pt_n = pt_hit;
			if (pt_hit) begin
				b_en = 1'b1;
			end else begin
				if (enc) begin
					b_en = (pos_e != '0) || blk_end;
					tail = ((pos_e != '0) && blk_end) ? bbrc_pkg::TAIL_W'(1) : '0;
					if (pos_e == '0) begin
						held_we = 1'b1;
					end
				end else begin
					b_en = blk_end;
					tail = blk_end ? bbrc_pkg::TAIL_W'(pos_e) : '0;
					if (!blk_end) begin
						held_we = 1'b1;
						held_wa = pos_e[HIDX_W-1:0];
					end
				end
				if (blk_end) begin
					pos_n = '0;
					si_n  = (si_e == SI_LAST) ? '0 : si_e + 1'b1;
				end else begin
					pos_n = pos_e + 1'b1;
				end
			end
		end

		desc.load     = key_load || b_en || (tail != '0);
		desc.key_en   = key_load;
		desc.key      = key_word;
		desc.b_en     = b_en;
		desc.b        = item.in_byte;
		desc.tail_cnt = tail;
	end

	assign held = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lengths_q <= '0;
			si_q      <= '0;
			bd_q      <= '0;
			hc_q      <= '0;
			pos_q     <= '0;
			pt_q      <= 1'b0;
		end else if (take) begin
			lengths_q <= lengths_n;
			si_q      <= si_n;
			bd_q      <= bd_n;
			hc_q      <= hc_n;
			pos_q     <= pos_n;
			pt_q      <= pt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && held_we) begin
			held_q[held_wa] <= item.in_byte;
		end
	end

endmodule

FILE: hdl/bbrc_out.sv
// Result register that plays out one run of output bytes, one per transaction.
`timescale 1ns / 1ps
module bbrc_out #(
	parameter int MAX_BLOCK = bbrc_pkg::MAX_BLOCK_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  bbrc_pkg::run_desc_t       desc,
	input  logic [MAX_BLOCK-2:0][7:0] held,
	output logic                      free,
	output logic                      result_valid,
	input  logic                      result_ready,
	output bbrc_pkg::out_item_t       result
);

	localparam int RUN_MAX = (MAX_BLOCK > 6) ? MAX_BLOCK : 6;
	localparam int CNT_W   = $clog2(RUN_MAX + 1);
	localparam int HIDX_W  = (MAX_BLOCK > 2) ? $clog2(MAX_BLOCK - 1) : 1;

	logic                      busy_q;
	logic [CNT_W-1:0]          idx_q, total_q;
	logic                      key_en_q, b_en_q;
	logic [31:0]               key_q;
	logic [7:0]                b_q;
	logic [MAX_BLOCK-2:0][7:0] held_q;

	logic             last;
	logic [CNT_W-1:0] rel, hrel;

	assign last         = (idx_q == total_q - 1'b1);
	assign free         = !busy_q || (result_ready && last);
	assign result_valid = busy_q;

	always_comb begin
		rel  = key_en_q ? idx_q - CNT_W'(bbrc_pkg::KEY_BYTES) : idx_q;
		hrel = rel - CNT_W'(b_en_q);
		if (key_en_q && (idx_q < CNT_W'(bbrc_pkg::KEY_BYTES))) begin
			result.out_byte = key_q[{~idx_q[1:0], 3'b000} +: 8];
		end else if (b_en_q && (rel == '0)) begin
			result.out_byte = b_q;
		end else begin
			result.out_byte = held_q[hrel[HIDX_W-1:0]];
		end
		result.last_of_run = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && result_ready) begin
			if (last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			total_q  <= (desc.key_en ? CNT_W'(bbrc_pkg::KEY_BYTES) : '0) + CNT_W'(desc.b_en)
				+ CNT_W'(desc.tail_cnt);
			key_en_q <= desc.key_en;
			b_en_q   <= desc.b_en;
			key_q    <= desc.key;
			b_q      <= desc.b;
			held_q   <= held;
		end
	end

endmodule

FILE: hdl/byte_block_rotation_cipher_top.sv
// Byte block rotation cipher: users send a byte stream in and take the
// transformed byte stream out, each direction as valid/ready transactions.
// Configuration registers (direction, key word, payload length) are written
// through the cfg channel by index; users must write them only while the
// block is idle, which the block does not enforce. cfg_ready is always high.
// An item first lands in an input register and is processed once the result
// register can take any run it causes; that register then offers the item's
// results one per cycle while the receiver is ready. Each item yields zero to
// fifteen results; last_of_run marks the final one. Input and output overlap,
// so encryption sustains one byte per cycle plus four key bytes per message;
// decryption holds a block and then releases it as one run of as many bytes,
// during which further items that cause results wait in the input register.
// The rate is set by the single result register, carrying one byte a cycle.
// When the receiver stalls, the current result holds and the input side fills
// and then deasserts item_ready. Reset clears all counters, the block lengths
// and the configuration registers; held bytes need no clearing.
`timescale 1ns / 1ps
`include "byte_block_rotation_cipher_top_defines.svh"
module byte_block_rotation_cipher_top #(
	parameter int MAX_BLOCK    = bbrc_pkg::MAX_BLOCK_DEF,
	parameter int SCHEDULE_LEN = bbrc_pkg::SCHEDULE_LEN_DEF,
	parameter int LENGTH_BITS  = bbrc_pkg::LENGTH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  bbrc_pkg::in_item_t                item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output bbrc_pkg::out_item_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bbrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	logic                 valid_s1;
	bbrc_pkg::in_item_t   item_s1;
	logic                 take_s1;
	logic                 direction_q;
	logic [31:0]          key_q;
	logic [15:0]          length_q;
	bbrc_pkg::run_desc_t  desc;
	logic [MAX_BLOCK-2:0][7:0] held;
	logic                 out_free;

	assign cfg_ready  = 1'b1;
	assign take_s1    = valid_s1 && (!desc.load || out_free);
	assign item_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= bbrc_pkg::DIR_ENCRYPT;
			key_q       <= '0;
			length_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bbrc_pkg::CFG_DIRECTION: begin
					direction_q <= cfg_data[0];
				end
				bbrc_pkg::CFG_KEY_WORD: begin
					key_q <= cfg_data;
				end
				bbrc_pkg::CFG_PAYLOAD_LENGTH: begin
					length_q <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	bbrc_core #(
		.MAX_BLOCK   (MAX_BLOCK),
		.SCHEDULE_LEN(SCHEDULE_LEN),
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take_s1),
		.item          (item_s1),
		.direction     (direction_q),
		.key_word      (key_q),
		.payload_length(length_q),
		.desc          (desc),
		.held          (held)
	);

	bbrc_out #(
		.MAX_BLOCK(MAX_BLOCK)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take_s1 && desc.load),
		.desc        (desc),
		.held        (held),
		.free        (out_free),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	`BBRC_NEVER(a_no_run_overwrite,
		take_s1 && desc.load && result_valid && !(result_ready && result.last_of_run),
		"New run loaded over a run that is still playing out.")
	`BBRC_IMPLIES(a_stall_needs_item, !item_ready, valid_s1,
		"Input stalled with an empty input register.")
	`BBRC_NEXT(a_key_leads_message,
		take_s1 && item_s1.message_start && (direction_q == bbrc_pkg::DIR_ENCRYPT),
		result_valid && (result.out_byte == $past(key_q[31:24])),
		"Encrypted message does not open with the first key byte.")

endmodule
